// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// Self-contained; needs no other file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== design/uesba_pkg.sv =====
// Shared types and constants of the USB endpoint slot and buffer allocator.
// No dependencies.
package uesba_pkg;

  localparam int unsigned EpW   = 4;
  localparam int unsigned SizeW = 11;
  localparam int unsigned AddrW = 12;
  localparam int unsigned PtrW  = 13;
  localparam int unsigned SlotW = 3;
  localparam int unsigned CodeW = EpW + 1;

  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  // Word index of the buffer top register, from paddr[PaddrW-1:2].
  localparam logic [PaddrW-3:0] RegBufferTop = '0;

  localparam logic [PtrW-1:0]  BufTopReset      = 13'h1000;
  localparam logic [SizeW-1:0] ControlSizeReset = 11'd64;

  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_SET_IN  = 2'd1,
    KIND_SET_OUT = 2'd2,
    KIND_LOOKUP  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_SLOT   = 2'd1,
    STATUS_NO_SPACE  = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_e;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic capture;  // latch the request
    logic search;   // match and claim slots, start the entry read
    logic eval;     // compute and load the result, commit state
  } cmd_t;

endpackage

// ===== design/uesba_if.sv =====
// Request and response channel interfaces of the endpoint slot allocator.
// Depends on uesba_pkg.
interface uesba_req_if import uesba_pkg::*; ();
  logic             valid;
  logic             ready;
  kind_e            kind;
  logic [EpW-1:0]   ep_number;
  logic             direction_in;
  logic [SizeW-1:0] packet_size;

  modport source (output valid, kind, ep_number, direction_in, packet_size, input ready);
  modport sink   (input valid, kind, ep_number, direction_in, packet_size, output ready);
endinterface

interface uesba_rsp_if import uesba_pkg::*; ();
  logic             valid;
  logic             ready;
  status_e          status;
  logic [SlotW-1:0] slot;
  logic             slot_valid;
  logic [AddrW-1:0] buf_start;
  logic [AddrW-1:0] buf_end;
  logic [SizeW-1:0] max_packet;

  modport source (output valid, status, slot, slot_valid, buf_start, buf_end, max_packet,
                  input ready);
  modport sink   (input valid, status, slot, slot_valid, buf_start, buf_end, max_packet,
                  output ready);
endinterface

// ===== design/uesba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module uesba_ram #(
  parameter int unsigned WIDTH = 35,
  parameter int unsigned DEPTH = 6,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/uesba_ctrl.sv =====
// Request sequencer of the endpoint slot allocator: capture, search, evaluate.
// Depends on uesba_pkg.
module uesba_ctrl import uesba_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  logic rsp_ready_i,
  output logic req_ready_o,
  output logic rsp_valid_o,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_EVAL   = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;
  logic   out_free;

  assign out_free = !rsp_valid_q || rsp_ready_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd_o.search = 1'b1;
        state_d      = ST_EVAL;
      end
      ST_EVAL: begin
        // hold until the output register can take the new result
        if (out_free) begin
          cmd_o.eval  = 1'b1;
          rsp_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;

endmodule

// ===== design/uesba_dp.sv =====
// Datapath of the endpoint slot allocator: slot table, buffer pointer, result.
// Depends on uesba_pkg and uesba_ram.
module uesba_dp import uesba_pkg::*; #(
  parameter int unsigned SLOTS = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  input  kind_e            kind_i,
  input  logic [EpW-1:0]   ep_number_i,
  input  logic             direction_in_i,
  input  logic [SizeW-1:0] packet_size_i,
  input  logic             cfg_we_i,
  input  logic [PtrW-1:0]  cfg_wdata_i,
  output logic [PtrW-1:0]  buffer_top_o,
  output status_e          status_o,
  output logic [SlotW-1:0] slot_o,
  output logic             slot_valid_o,
  output logic [AddrW-1:0] buf_start_o,
  output logic [AddrW-1:0] buf_end_o,
  output logic [SizeW-1:0] max_packet_o
);

  localparam int unsigned IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned EntW  = 2 * AddrW + SizeW;

  // latched request
  kind_e            kind_q;
  logic [EpW-1:0]   ep_q;
  logic             dir_q;
  logic [SizeW-1:0] size_q;

  // slot table and allocation state
  logic [SLOTS-1:0] used_q;
  logic [CodeW-1:0] code_q [SLOTS];
  logic [PtrW-1:0]  top_q;
  logic [PtrW-1:0]  ptr_q, ptr_d;
  logic [SizeW-1:0] csize_q, csize_d;

  // search results
  logic            hit, free;
  logic [IdxW-1:0] hit_idx, free_idx;
  logic            hit_q, free_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q;

  logic             is_in, is_set, ep_zero, claim, clear;
  logic [CodeW-1:0] own_code, key;

  logic [EntW-1:0]  rdata, wdata;
  logic [AddrW-1:0] rd_start, rd_end;
  logic [SizeW-1:0] rd_size;

  logic [AddrW-1:0] rounded;
  logic             fits;
  logic [PtrW-1:0]  carve_ptr;
  logic [AddrW-1:0] carve_start, carve_end;

  status_e          res_status;
  logic [IdxW-1:0]  res_idx;
  logic             res_valid, ent_we;
  logic [AddrW-1:0] res_start, res_end;
  logic [SizeW-1:0] res_mp;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      ep_q   <= ep_number_i;
      dir_q  <= direction_in_i;
      size_q <= packet_size_i;
    end
  end

  assign is_set   = (kind_q == KIND_SET_IN) || (kind_q == KIND_SET_OUT);
  assign is_in    = (kind_q == KIND_LOOKUP) ? dir_q : (kind_q == KIND_SET_IN);
  assign ep_zero  = (ep_q == '0);
  assign own_code = {is_in, ep_q};
  // a set looks for the opposite direction, a lookup for its own
  assign key      = (kind_q == KIND_LOOKUP) ? own_code : {!is_in, ep_q};

  // lowest matching slot and lowest free slot
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free     = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (used_q[i] && (code_q[i] == key)) begin
        hit     = 1'b1;
        hit_idx = IdxW'(i);
      end
      if (!used_q[i]) begin
        free     = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  assign claim = cmd_i.search && is_set && !ep_zero && free;
  assign clear = cmd_i.eval && (kind_q == KIND_CLEAR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (clear) begin
      used_q <= '0;
    end else if (claim) begin
      used_q[free_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (claim) begin
      code_q[free_idx] <= own_code;
    end
    if (cmd_i.search) begin
      hit_q      <= hit;
      hit_idx_q  <= hit_idx;
      free_q     <= free;
      free_idx_q <= free_idx;
    end
  end

  uesba_ram #(
    .WIDTH(EntW),
    .DEPTH(SLOTS)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.eval && ent_we),
    .waddr_i(free_idx_q),
    .wdata_i(wdata),
    .re_i   (cmd_i.search),
    .raddr_i(hit_idx),
    .rdata_o(rdata)
  );

  assign {rd_start, rd_end, rd_size} = rdata;
  assign wdata = {res_start, res_end, size_q};

  // Carve top-down: start = ptr - round_even(size); end = start + size - 1,
  // which reduces to ptr - 1 - size[0].
  assign rounded     = {1'b0, size_q} + AddrW'(size_q[0]);
  assign fits        = ({1'b0, rounded} <= ptr_q);
  assign carve_ptr   = ptr_q - {1'b0, rounded};
  assign carve_start = carve_ptr[AddrW-1:0];
  assign carve_end   = ptr_q[AddrW-1:0] - AddrW'(1) - AddrW'(size_q[0]);

  always_comb begin
    res_status = STATUS_OK;
    res_idx    = '0;
    res_valid  = 1'b0;
    res_start  = '0;
    res_end    = '0;
    res_mp     = '0;
    ent_we     = 1'b0;
    ptr_d      = ptr_q;
    csize_d    = csize_q;
    case (kind_q)
      KIND_CLEAR: begin
        ptr_d = top_q;
      end
      KIND_LOOKUP: begin
        if (ep_zero) begin
          res_mp = csize_q;
        end else if (hit_q) begin
          res_idx   = hit_idx_q;
          res_valid = 1'b1;
          res_start = rd_start;
          res_end   = rd_end;
          res_mp    = rd_size;
        end else begin
          res_status = STATUS_NOT_FOUND;
        end
      end
      KIND_SET_IN, KIND_SET_OUT: begin
        if (ep_zero) begin
          // control endpoint: only an IN set carves a buffer
          if (kind_q == KIND_SET_IN) begin
            if (fits) begin
              ptr_d     = carve_ptr;
              res_start = carve_start;
              res_end   = carve_end;
              res_mp    = size_q;
              csize_d   = size_q;
            end else begin
              res_status = STATUS_NO_SPACE;
            end
          end
        end else if (!free_q) begin
          res_status = STATUS_NO_SLOT;
        end else begin
          res_idx   = free_idx_q;
          res_valid = 1'b1;
          if (hit_q) begin
            // share the opposite direction's buffer
            res_start = rd_start;
            res_end   = rd_end;
            res_mp    = size_q;
            ent_we    = 1'b1;
          end else if (fits) begin
            ptr_d     = carve_ptr;
            res_start = carve_start;
            res_end   = carve_end;
            res_mp    = size_q;
            ent_we    = 1'b1;
          end else begin
            res_status = STATUS_NO_SPACE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q   <= BufTopReset;
      ptr_q   <= BufTopReset;
      csize_q <= ControlSizeReset;
    end else begin
      if (cfg_we_i) begin
        top_q <= cfg_wdata_i;
      end
      if (cmd_i.eval) begin
        ptr_q   <= ptr_d;
        csize_q <= csize_d;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      status_o     <= res_status;
      slot_o       <= SlotW'(res_idx);
      slot_valid_o <= res_valid;
      buf_start_o  <= res_start;
      buf_end_o    <= res_end;
      max_packet_o <= res_mp;
    end
  end

  assign buffer_top_o = top_q;

endmodule

// ===== design/usb_endpoint_slot_buffer_allocator.sv =====
// USB endpoint slot and buffer allocator. Each request (clear, set IN size,
// set OUT size, lookup) gives exactly one response. The request is latched at
// the edge that accepts it. A search step then matches the slot table and reads
// the slot's buffer entry from the entry RAM; a compute step then works out the
// result, updates the allocation pointer, writes the entry RAM and loads the
// output register. A new request is accepted as soon as that result sits in the
// output register, so requests do not overlap; a stalled response holds the
// compute step. buffer_top is written through the APB port at offset 0 and
// takes effect at the next clear.
// Depends on uesba_pkg, uesba_if, uesba_ctrl, uesba_dp and uesba_ram.
module usb_endpoint_slot_buffer_allocator import uesba_pkg::*; #(
  parameter int unsigned SLOTS = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  uesba_req_if.sink         req_i,
  uesba_rsp_if.source       rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  cmd_t            cmd;
  logic            cfg_hit, cfg_we;
  logic [PtrW-1:0] buffer_top;

  assign cfg_hit = (paddr[PaddrW-1:2] == RegBufferTop);
  assign cfg_we  = psel && penable && pwrite && cfg_hit;
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? PdataW'(buffer_top) : '0;

  uesba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_i.valid),
    .rsp_ready_i(rsp_o.ready),
    .req_ready_o(req_i.ready),
    .rsp_valid_o(rsp_o.valid),
    .cmd_o      (cmd)
  );

  uesba_dp #(
    .SLOTS(SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .kind_i        (req_i.kind),
    .ep_number_i   (req_i.ep_number),
    .direction_in_i(req_i.direction_in),
    .packet_size_i (req_i.packet_size),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (pwdata[PtrW-1:0]),
    .buffer_top_o  (buffer_top),
    .status_o      (rsp_o.status),
    .slot_o        (rsp_o.slot),
    .slot_valid_o  (rsp_o.slot_valid),
    .buf_start_o   (rsp_o.buf_start),
    .buf_end_o     (rsp_o.buf_end),
    .max_packet_o  (rsp_o.max_packet)
  );

endmodule

// ===== design/uesba_checker.sv =====
// Port-level checks of the endpoint slot allocator, bound to its top level.
// Depends on uesba_pkg and assert_macros.svh.
`include "assert_macros.svh"

module uesba_checker import uesba_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_valid_i,
  input logic             req_ready_i,
  input logic             rsp_valid_i,
  input logic             rsp_ready_i,
  input status_e          status_i,
  input logic [SlotW-1:0] slot_i,
  input logic             slot_valid_i,
  input logic [AddrW-1:0] buf_start_i,
  input logic [AddrW-1:0] buf_end_i,
  input logic [SizeW-1:0] max_packet_i
);

  // a pending response stays offered until taken
  `ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i)

  // a failed request reports no buffer and no size
  `ASSERT_IMPLY(a_fail_zero, clk_i, rst_ni, rsp_valid_i && (status_i != STATUS_OK), (buf_start_i == '0) && (buf_end_i == '0) && (max_packet_i == '0))

  // no slot named means slot field zero
  `ASSERT_IMPLY(a_slot_zero, clk_i, rst_ni, rsp_valid_i && !slot_valid_i, slot_i == '0)

  // the block is busy right after it takes a transfer
  `ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i)

endmodule

bind usb_endpoint_slot_buffer_allocator uesba_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .status_i    (rsp_o.status),
  .slot_i      (rsp_o.slot),
  .slot_valid_i(rsp_o.slot_valid),
  .buf_start_i (rsp_o.buf_start),
  .buf_end_i   (rsp_o.buf_end),
  .max_packet_i(rsp_o.max_packet)
);

// ===== sim/usb_endpoint_slot_buffer_allocator_test.sv =====
// Self-checking testbench for the USB endpoint slot and buffer allocator.
// Drives request transfers, predicts every response from a slot table of its own and
// checks each field; needs uesba_pkg, uesba_if and the allocator RTL.
module usb_endpoint_slot_buffer_allocator_test import uesba_pkg::*; ();

  localparam int unsigned SlotCount  = 6;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 60;
  localparam int unsigned PrintCap   = 40;

  typedef struct packed {
    kind_e            kind;
    logic [EpW-1:0]   ep;
    logic             dir_in;
    logic [SizeW-1:0] pkt_size;
  } alloc_req_t;

  typedef struct packed {
    status_e          status;
    logic [SlotW-1:0] slot;
    logic             slot_valid;
    logic [AddrW-1:0] buf_start;
    logic [AddrW-1:0] buf_end;
    logic [SizeW-1:0] max_packet;
  } alloc_rsp_t;

  typedef struct packed {
    logic [PtrW-1:0]                 top;
    logic [PtrW-1:0]                 ptr;
    logic [SizeW-1:0]                ctrl_size;
    logic [SlotCount-1:0]            used;
    logic [SlotCount-1:0]            written;
    logic [SlotCount-1:0][CodeW-1:0] code;
    logic [SlotCount-1:0][AddrW-1:0] start_addr;
    logic [SlotCount-1:0][AddrW-1:0] end_addr;
    logic [SlotCount-1:0][SizeW-1:0] pkt_size;
  } slot_table_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  uesba_req_if req_if ();
  uesba_rsp_if rsp_if ();

  usb_endpoint_slot_buffer_allocator #(.SLOTS(SlotCount)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // live_table follows accepted requests; plan_table runs ahead while stimulus is queued
  slot_table_t  live_table;
  slot_table_t  plan_table;
  alloc_req_t   pending_req_q[$];
  alloc_rsp_t   expected_rsp_q[$];
  alloc_req_t   drive_req;
  alloc_req_t   seen_req;
  alloc_rsp_t   want_rsp;
  bit           blank_unused;
  logic [EpW-1:0] hot_ep[3];
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  int unsigned  mismatches;
  int unsigned  requests_taken;
  int unsigned  status_seen[4];
  int unsigned  cycles;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("run timed out after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PrintCap)
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
  endtask

  function automatic int find_slot_of(input slot_table_t t, input logic [CodeW-1:0] c);
    for (int i = 0; i < SlotCount; i++)
      if (t.used[i] && t.code[i] == c) return i;
    return -1;
  endfunction

  // Predict one response and advance the table; flag reads of entries never written.
  function automatic alloc_rsp_t predict_allocation(inout slot_table_t t,
                                                    input alloc_req_t r,
                                                    output bit blank_read);
    alloc_rsp_t      res;
    int              hit;
    int              twin;
    int              claim;
    logic [PtrW-1:0] rounded;
    logic            is_in;
    logic            fits;
    res = '0;
    blank_read = 1'b0;
    rounded = (PtrW'(r.pkt_size) + 1'b1) & ~PtrW'(1);
    fits = (rounded <= t.ptr);
    is_in = (r.kind == KIND_SET_IN);
    case (r.kind)
      KIND_CLEAR: begin
        t.used = '0;
        t.ptr = t.top;
      end
      KIND_LOOKUP: begin
        if (r.ep == '0) begin
          res.max_packet = t.ctrl_size;
        end else begin
          hit = find_slot_of(t, {r.dir_in, r.ep});
          if (hit < 0) begin
            res.status = STATUS_NOT_FOUND;
          end else begin
            blank_read = !t.written[hit];
            res.slot = SlotW'(hit);
            res.slot_valid = 1'b1;
            res.buf_start = t.start_addr[hit];
            res.buf_end = t.end_addr[hit];
            res.max_packet = t.pkt_size[hit];
          end
        end
      end
      default: begin
        if (r.ep == '0) begin
          // control endpoint: IN carves the control buffer, OUT does nothing
          if (is_in && !fits) begin
            res.status = STATUS_NO_SPACE;
          end else if (is_in) begin
            t.ptr = t.ptr - rounded;
            res.buf_start = t.ptr[AddrW-1:0];
            res.buf_end = t.ptr[AddrW-1:0] + AddrW'(r.pkt_size) - 1'b1;
            res.max_packet = r.pkt_size;
            t.ctrl_size = r.pkt_size;
          end
        end else begin
          twin = find_slot_of(t, {~is_in, r.ep});
          claim = -1;
          for (int i = SlotCount - 1; i >= 0; i--)
            if (!t.used[i]) claim = i;
          if (twin >= 0 && !t.written[twin]) blank_read = 1'b1;
          if (claim < 0) begin
            res.status = STATUS_NO_SLOT;
          end else begin
            t.used[claim] = 1'b1;
            t.code[claim] = {is_in, r.ep};
            res.slot = SlotW'(claim);
            res.slot_valid = 1'b1;
            if (twin >= 0) begin
              res.buf_start = t.start_addr[twin];
              res.buf_end = t.end_addr[twin];
            end else if (fits) begin
              t.ptr = t.ptr - rounded;
              res.buf_start = t.ptr[AddrW-1:0];
              res.buf_end = t.ptr[AddrW-1:0] + AddrW'(r.pkt_size) - 1'b1;
            end else begin
              res.status = STATUS_NO_SPACE;
            end
            // a failed carve keeps the claim but leaves the entry alone
            if (res.status == STATUS_OK) begin
              t.start_addr[claim] = res.buf_start;
              t.end_addr[claim] = res.buf_end;
              t.pkt_size[claim] = r.pkt_size;
              t.written[claim] = 1'b1;
              res.max_packet = r.pkt_size;
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  // Queue a request unless it would read a slot entry that was never written.
  function automatic bit queue_request(input alloc_req_t r);
    slot_table_t trial;
    bit          blank;
    trial = plan_table;
    void'(predict_allocation(trial, r, blank));
    if (blank) return 1'b0;
    plan_table = trial;
    pending_req_q.push_back(r);
    return 1'b1;
  endfunction

  function automatic alloc_req_t make_req(input kind_e k, input int ep, input bit d,
                                          input int sz);
    alloc_req_t r;
    r.kind = k;
    r.ep = EpW'(ep);
    r.dir_in = d;
    r.pkt_size = SizeW'(sz);
    return r;
  endfunction

  // Mostly sets and lookups on a few hot endpoints, some clears, some pure noise.
  function automatic alloc_req_t random_request();
    alloc_req_t  r;
    int unsigned pick;
    r.kind = kind_e'($urandom_range(3));
    r.ep = EpW'($urandom);
    r.dir_in = 1'($urandom);
    r.pkt_size = SizeW'($urandom);
    pick = $urandom_range(99);
    if (pick < 10) return r;
    r.ep = (pick < 20) ? '0 : hot_ep[$urandom_range(2)];
    if (pick < 26) r.kind = KIND_CLEAR;
    else if (pick < 62) r.kind = $urandom_range(1) ? KIND_SET_IN : KIND_SET_OUT;
    else r.kind = KIND_LOOKUP;
    case ($urandom_range(9))
      0: r.pkt_size = '0;
      1: r.pkt_size = SizeW'($urandom_range(1024, 2047));
      2, 3: r.pkt_size = SizeW'($urandom_range(1, 1023));
      default: r.pkt_size = SizeW'(8 << $urandom_range(6));
    endcase
    return r;
  endfunction

  task automatic write_buffer_top(input logic [PtrW-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {RegBufferTop, 2'b00};
    pwdata <= PdataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    live_table.top = value;
    plan_table.top = value;
    // read back through a second transfer
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== PdataW'(value)) report_mismatch("buffer_top readback", prdata, value);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // sample between edges so the driver's updates of this cycle are visible
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_req_q.size() != 0 || req_if.valid || expected_rsp_q.size() != 0);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_if.ready) begin
      if (pending_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_req = pending_req_q.pop_front();
        req_if.valid <= 1'b1;
        req_if.kind <= drive_req.kind;
        req_if.ep_number <= drive_req.ep;
        req_if.direction_in <= drive_req.dir_in;
        req_if.packet_size <= drive_req.pkt_size;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        seen_req.kind = req_if.kind;
        seen_req.ep = req_if.ep_number;
        seen_req.dir_in = req_if.direction_in;
        seen_req.pkt_size = req_if.packet_size;
        expected_rsp_q.push_back(predict_allocation(live_table, seen_req, blank_unused));
        requests_taken++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("response with nothing pending, status", rsp_if.status, 0);
        end else begin
          want_rsp = expected_rsp_q.pop_front();
          status_seen[want_rsp.status]++;
          if (rsp_if.status !== want_rsp.status)
            report_mismatch("status", rsp_if.status, want_rsp.status);
          if (rsp_if.slot !== want_rsp.slot)
            report_mismatch("slot", rsp_if.slot, want_rsp.slot);
          if (rsp_if.slot_valid !== want_rsp.slot_valid)
            report_mismatch("slot_valid", rsp_if.slot_valid, want_rsp.slot_valid);
          if (rsp_if.buf_start !== want_rsp.buf_start)
            report_mismatch("buf_start", rsp_if.buf_start, want_rsp.buf_start);
          if (rsp_if.buf_end !== want_rsp.buf_end)
            report_mismatch("buf_end", rsp_if.buf_end, want_rsp.buf_end);
          if (rsp_if.max_packet !== want_rsp.max_packet)
            report_mismatch("max_packet", rsp_if.max_packet, want_rsp.max_packet);
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int unsigned     placed;
    logic [PtrW-1:0] top_value;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_if.valid = 1'b0;
    req_if.kind = KIND_CLEAR;
    req_if.ep_number = '0;
    req_if.direction_in = 1'b0;
    req_if.packet_size = '0;
    rsp_if.ready = 1'b0;
    cycles = 0;
    mismatches = 0;
    requests_taken = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    live_table = '0;
    live_table.top = BufTopReset;
    live_table.ptr = BufTopReset;
    live_table.ctrl_size = ControlSizeReset;
    plan_table = live_table;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_buffer_top(BufTopReset);

    // control endpoint, shared buffers, odd and zero sizes, every failure status
    void'(queue_request(make_req(KIND_LOOKUP, 0, 1'b0, 0)));
    void'(queue_request(make_req(KIND_SET_IN, 0, 1'b0, 64)));
    void'(queue_request(make_req(KIND_SET_OUT, 0, 1'b1, 100)));
    void'(queue_request(make_req(KIND_SET_IN, 1, 1'b0, 1)));
    void'(queue_request(make_req(KIND_SET_OUT, 1, 1'b1, 512)));
    void'(queue_request(make_req(KIND_LOOKUP, 1, 1'b1, 0)));
    void'(queue_request(make_req(KIND_LOOKUP, 1, 1'b0, 2047)));
    void'(queue_request(make_req(KIND_SET_IN, 15, 1'b1, 0)));
    void'(queue_request(make_req(KIND_SET_OUT, 2, 1'b0, 1023)));
    void'(queue_request(make_req(KIND_SET_IN, 3, 1'b0, 2047)));
    void'(queue_request(make_req(KIND_SET_OUT, 4, 1'b0, 1024)));
    void'(queue_request(make_req(KIND_SET_IN, 1, 1'b0, 8)));
    void'(queue_request(make_req(KIND_LOOKUP, 7, 1'b0, 0)));
    void'(queue_request(make_req(KIND_LOOKUP, 15, 1'b1, 0)));
    void'(queue_request(make_req(KIND_LOOKUP, 0, 1'b1, 0)));
    void'(queue_request(make_req(KIND_CLEAR, 15, 1'b1, 2047)));
    void'(queue_request(make_req(KIND_SET_IN, 5, 1'b0, 16)));
    void'(queue_request(make_req(KIND_SET_IN, 5, 1'b0, 16)));
    void'(queue_request(make_req(KIND_LOOKUP, 5, 1'b1, 0)));
    void'(queue_request(make_req(KIND_SET_IN, 0, 1'b0, 2047)));
    void'(queue_request(make_req(KIND_SET_IN, 0, 1'b0, 2015)));
    void'(queue_request(make_req(KIND_SET_IN, 0, 1'b0, 1)));
    void'(queue_request(make_req(KIND_SET_OUT, 6, 1'b0, 0)));
    void'(queue_request(make_req(KIND_LOOKUP, 6, 1'b0, 0)));
    void'(queue_request(make_req(KIND_LOOKUP, 0, 1'b0, 0)));
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      case (phase)
        0: top_value = BufTopReset;
        1: top_value = '0;
        4: top_value = PtrW'(300);
        6: top_value = PtrW'(2048);
        7: top_value = BufTopReset;
        default: top_value = PtrW'($urandom_range(4096));
      endcase
      write_buffer_top(top_value);
      for (int h = 0; h < 3; h++) hot_ep[h] = EpW'($urandom_range(1, 15));
      // start each setting from a clear so the new top is in use
      void'(queue_request(make_req(KIND_CLEAR, 0, 1'b0, 0)));
      placed = 0;
      while (placed < PhaseItems)
        if (queue_request(random_request())) placed++;
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    $display("%0d requests checked across eight buffer tops and four idle mixes",
             requests_taken);
    $display("responses: %0d ok, %0d no slot, %0d no space, %0d not found, %0d mismatches",
             status_seen[STATUS_OK], status_seen[STATUS_NO_SLOT],
             status_seen[STATUS_NO_SPACE], status_seen[STATUS_NOT_FOUND], mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
